### hdl/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types, opcodes and status codes of the RV32I execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rvx_pkg;

    localparam int unsigned MEM_BYTES = 16384;

    // Major opcodes.
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;
    localparam logic [6:0] OP_FENCE  = 7'b0001111;
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    localparam logic [4:0] SHAMT_MASK = 5'h1F;

    // funct3 codes.
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    localparam logic [2:0] F3_B    = 3'd0;
    localparam logic [2:0] F3_H    = 3'd1;
    localparam logic [2:0] F3_W    = 3'd2;
    localparam logic [2:0] F3_BU   = 3'd4;
    localparam logic [2:0] F3_HU   = 3'd5;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ECALL    = 3'd1,
        ST_EBREAK   = 3'd2,
        ST_ILLEGAL  = 3'd3,
        ST_MEMFAULT = 3'd4
    } t_status;

    typedef struct packed {
        logic        word_bit30;
        logic [31:0] immediate;
        logic [6:0]  alt_op;
        logic [2:0]  sub_op;
        logic [4:0]  src_reg_b;
        logic [4:0]  src_reg_a;
        logic [4:0]  dest_reg;
        logic [6:0]  major_opcode;
    } t_instr;

    // Outcome of the execute step, handed to memory and write-back.
    typedef struct packed {
        t_status     status;
        logic [31:0] next_pc;
        logic        wr;
        logic [31:0] value;
        logic        is_load;
        logic        is_store;
        logic [31:0] addr;
        logic [2:0]  size;
    } t_ex_res;

endpackage

`default_nettype wire

### hdl/rvx_regfile.sv
// ----------------------------------------------------------------------------
// rvx_regfile
// 32 x 32 register memory, two synchronous read ports, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_regfile (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rd_en,
    input  wire logic [4:0]  i_ra,
    input  wire logic [4:0]  i_rb,
    output logic      [31:0] o_qa,
    output logic      [31:0] o_qb,
    input  wire logic        i_we,
    input  wire logic [4:0]  i_wa,
    input  wire logic [31:0] i_wd
);

    logic [31:0] mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_qa;
    logic [31:0] r_qb;

    // Entries not yet written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wa] <= i_wd;
        end
    end

    // A write at the same edge is passed straight through to the read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_ra == 5'd0) begin
                r_qa <= '0;
            end else if (i_we && i_wa == i_ra) begin
                r_qa <= i_wd;
            end else begin
                r_qa <= r_vld[i_ra] ? mem[i_ra] : '0;
            end
            if (i_rb == 5'd0) begin
                r_qb <= '0;
            end else if (i_we && i_wa == i_rb) begin
                r_qb <= i_wd;
            end else begin
                r_qb <= r_vld[i_rb] ? mem[i_rb] : '0;
            end
        end
    end

    assign o_qa = r_qa;
    assign o_qb = r_qb;

endmodule

`default_nettype wire

### hdl/rvx_alu.sv
// ----------------------------------------------------------------------------
// rvx_alu
// Execute step: ALU, branch decision, address generation and legality checks.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_alu #(
    parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES
) (
    input  wire rvx_pkg::t_instr  i_instr,
    input  wire logic [31:0]      i_pc,
    input  wire logic [31:0]      i_a,
    input  wire logic [31:0]      i_b,
    output rvx_pkg::t_ex_res      o_res
);

    localparam logic [32:0] LIMIT = 33'(MEM_BYTES);

    logic [31:0] imm;
    logic [31:0] pc4;
    logic [31:0] op_b;
    logic [4:0]  shamt;
    logic        alt;
    logic        lt_s;
    logic        lt_u;
    logic [31:0] alu;
    logic [31:0] addr;
    logic [2:0]  lsize;
    logic        in_rng;
    logic        take;

    always_comb begin
        imm   = i_instr.immediate;
        pc4   = i_pc + 32'd4;
        op_b  = (i_instr.major_opcode == rvx_pkg::OP_REG) ? i_b : imm;
        shamt = op_b[4:0] & rvx_pkg::SHAMT_MASK;
        alt   = (i_instr.major_opcode == rvx_pkg::OP_REG) ?
                (i_instr.alt_op == rvx_pkg::F7_ALT) : i_instr.word_bit30;
        lt_s  = $signed(i_a) < $signed(op_b);
        lt_u  = i_a < op_b;
        case (i_instr.sub_op)
            rvx_pkg::F3_ADD: alu = (alt && i_instr.major_opcode == rvx_pkg::OP_REG) ?
                                   i_a - op_b : i_a + op_b;
            rvx_pkg::F3_SLL:  alu = i_a << shamt;
            rvx_pkg::F3_SLT:  alu = {31'd0, lt_s};
            rvx_pkg::F3_SLTU: alu = {31'd0, lt_u};
            rvx_pkg::F3_XOR:  alu = i_a ^ op_b;
            rvx_pkg::F3_SR:   alu = alt ? 32'($signed(i_a) >>> shamt) : i_a >> shamt;
            rvx_pkg::F3_OR:   alu = i_a | op_b;
            default:          alu = i_a & op_b;
        endcase

        addr  = i_a + imm;
        case (i_instr.sub_op[1:0])
            2'd0:    lsize = 3'd1;
            2'd1:    lsize = 3'd2;
            default: lsize = 3'd4;
        endcase
        in_rng = ({1'b0, addr} + 33'(lsize)) <= LIMIT;

        case (i_instr.sub_op)
            rvx_pkg::F3_BEQ:  take = i_a == i_b;
            rvx_pkg::F3_BNE:  take = i_a != i_b;
            rvx_pkg::F3_BLT:  take = $signed(i_a) < $signed(i_b);
            rvx_pkg::F3_BGE:  take = !($signed(i_a) < $signed(i_b));
            rvx_pkg::F3_BLTU: take = i_a < i_b;
            rvx_pkg::F3_BGEU: take = !(i_a < i_b);
            default:          take = 1'b0;
        endcase

        o_res          = '0;
        o_res.status   = rvx_pkg::ST_OK;
        o_res.next_pc  = pc4;
        o_res.addr     = addr;
        o_res.size     = lsize;
        case (i_instr.major_opcode)
            rvx_pkg::OP_LUI: begin
                o_res.wr = 1'b1; o_res.value = imm;
            end
            rvx_pkg::OP_AUIPC: begin
                o_res.wr = 1'b1; o_res.value = i_pc + imm;
            end
            rvx_pkg::OP_JAL: begin
                o_res.wr = 1'b1; o_res.value = pc4; o_res.next_pc = i_pc + imm;
            end
            rvx_pkg::OP_JALR: begin
                o_res.wr = 1'b1; o_res.value = pc4; o_res.next_pc = addr & ~32'd1;
            end
            rvx_pkg::OP_BRANCH: begin
                if (i_instr.sub_op == rvx_pkg::F3_SLT || i_instr.sub_op == rvx_pkg::F3_SLTU) begin
                    o_res.status = rvx_pkg::ST_ILLEGAL;
                end else if (take) begin
                    o_res.next_pc = i_pc + imm;
                end
            end
            rvx_pkg::OP_LOAD: begin
                if (!(i_instr.sub_op == rvx_pkg::F3_B || i_instr.sub_op == rvx_pkg::F3_H ||
                      i_instr.sub_op == rvx_pkg::F3_W || i_instr.sub_op == rvx_pkg::F3_BU ||
                      i_instr.sub_op == rvx_pkg::F3_HU)) begin
                    o_res.status = rvx_pkg::ST_ILLEGAL;
                end else if (!in_rng) begin
                    o_res.status = rvx_pkg::ST_MEMFAULT;
                end else begin
                    o_res.wr = 1'b1; o_res.is_load = 1'b1;
                end
            end
            rvx_pkg::OP_STORE: begin
                if (i_instr.sub_op > rvx_pkg::F3_W) begin
                    o_res.status = rvx_pkg::ST_ILLEGAL;
                end else if (!in_rng) begin
                    o_res.status = rvx_pkg::ST_MEMFAULT;
                end else begin
                    o_res.is_store = 1'b1;
                end
            end
            rvx_pkg::OP_IMM, rvx_pkg::OP_REG: begin
                o_res.wr = 1'b1; o_res.value = alu;
            end
            rvx_pkg::OP_SYSTEM: begin
                if (i_instr.sub_op == 3'd0 && imm == 32'd0) begin
                    o_res.status = rvx_pkg::ST_ECALL;
                end else if (i_instr.sub_op == 3'd0 && imm == 32'd1) begin
                    o_res.status = rvx_pkg::ST_EBREAK;
                end else begin
                    o_res.status = rvx_pkg::ST_ILLEGAL;
                end
            end
            rvx_pkg::OP_FENCE: begin
                o_res.status = rvx_pkg::ST_OK;
            end
            default: begin
                o_res.status = rvx_pkg::ST_ILLEGAL;
            end
        endcase

        if (o_res.status == rvx_pkg::ST_ILLEGAL || o_res.status == rvx_pkg::ST_MEMFAULT) begin
            o_res.next_pc = i_pc;
            o_res.wr      = 1'b0;
        end
        if (i_instr.dest_reg == 5'd0) begin
            o_res.wr = 1'b0;
        end
    end

endmodule

`default_nettype wire

### hdl/rvx_dmem.sv
// ----------------------------------------------------------------------------
// rvx_dmem
// Data memory as four byte banks, with a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_dmem #(
    parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rd_en,
    input  wire logic        i_wr_en,
    input  wire logic [31:0] i_addr,
    input  wire logic [2:0]  i_size,
    input  wire logic [2:0]  i_sub_op,
    input  wire logic [31:0] i_wdata,
    output logic             o_busy,
    output logic      [31:0] o_load_value
);

    localparam int unsigned ROWS = (MEM_BYTES + 3) / 4;
    localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    logic          r_clr;
    logic [RW-1:0] r_clr_row;
    logic [1:0]    r_lane;
    logic [2:0]    r_sub_op;
    logic [7:0]    q [4];
    logic [31:0]   raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_row <= '0;
        end else if (r_clr) begin
            r_clr_row <= r_clr_row + RW'(1);
            if (r_clr_row == LAST_ROW) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_lane   <= i_addr[1:0];
            r_sub_op <= i_sub_op;
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [7:0]    mem [ROWS];
        logic [7:0]    r_q;
        logic [1:0]    off;
        logic [31:0]   baddr;
        logic [RW-1:0] row;
        logic          act;

        always_comb begin
            off   = 2'(k) - i_addr[1:0];
            baddr = i_addr + 32'(off);
            row   = baddr[RW+1:2];
            act   = 3'(off) < i_size;
        end

        always_ff @(posedge i_clk) begin
            if (r_clr) begin
                mem[r_clr_row] <= '0;
            end else if (i_wr_en && act) begin
                mem[row] <= i_wdata[8*off +: 8];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_rd_en) begin
                r_q <= mem[row];
            end
        end

        assign q[k] = r_q;
    end

    always_comb begin
        raw = {q[2'(r_lane + 2'd3)], q[2'(r_lane + 2'd2)], q[2'(r_lane + 2'd1)], q[r_lane]};
        case (r_sub_op)
            rvx_pkg::F3_B:  o_load_value = {{24{raw[7]}}, raw[7:0]};
            rvx_pkg::F3_H:  o_load_value = {{16{raw[15]}}, raw[15:0]};
            rvx_pkg::F3_BU: o_load_value = {24'd0, raw[7:0]};
            rvx_pkg::F3_HU: o_load_value = {16'd0, raw[15:0]};
            default:        o_load_value = raw;
        endcase
    end

    assign o_busy = r_clr;

endmodule

`default_nettype wire

### hdl/rv32i_execute_unit.sv
// ----------------------------------------------------------------------------
// rv32i_execute_unit
// RV32I execute stage with register file, program counter and data memory.
// ----------------------------------------------------------------------------
// Each request is one pre-decoded instruction; each yields one result with
// status, new PC and register write-back. The unit takes one instruction per
// cycle unless a later step is stalled or the memory is being cleared. An
// instruction passes three steps: the register memory read at acceptance,
// execute (ALU, branch, address, store, data memory read) and write-back (load
// formatting, register write), then the output register. Results of the two
// instructions ahead are forwarded, so dependent instructions follow back to
// back. After reset the data memory is cleared one row of four bytes per
// cycle, (MEM_BYTES+3)/4 rows, during which no instruction is accepted; the
// configuration port is always ready. Writing start_pc loads the program
// counter at once; the user must write it only while the unit is idle, the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_execute_unit #(
    parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // start_pc configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    // Instruction requests
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // major_opcode[6:0], dest_reg[11:7], src_reg_a[16:12], src_reg_b[21:17],
    // sub_op[24:22], alt_op[31:25], immediate[63:32], word_bit30[64]
    input  wire logic [71:0] s_axis_tdata,
    // Results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[2:0], new_pc[34:3], wb_enable[35], wb_index[40:36],
    // wb_value[72:41]
    output logic      [79:0] m_axis_tdata
);

    rvx_pkg::t_instr  in_instr;
    rvx_pkg::t_instr  r_s1_instr;
    rvx_pkg::t_ex_res ex_res;
    logic             r_s1_v;
    logic             r_s2_v;
    logic [31:0]      r_pc;
    logic [31:0]      qa;
    logic [31:0]      qb;
    logic [31:0]      fa;
    logic [31:0]      fb;

    // Write-back stage.
    rvx_pkg::t_status r_s2_status;
    logic [31:0]      r_s2_pc;
    logic             r_s2_wr;
    logic [4:0]       r_s2_rd;
    logic             r_s2_load;
    logic [31:0]      r_s2_val;
    logic [31:0]      s2_val;
    logic [31:0]      load_value;

    // Output register.
    logic             r_out_v;
    logic [79:0]      r_out;

    logic             busy;
    logic             out_free;
    logic             s2_move;
    logic             s2_free;
    logic             s1_move;
    logic             s1_free;
    logic             accept;

    assign in_instr = rvx_pkg::t_instr'(s_axis_tdata[64:0]);

    // Handshake chain: each step moves when the next one is free or leaving.
    always_comb begin
        out_free = !r_out_v || m_axis_tready;
        s2_move  = r_s2_v && out_free;
        s2_free  = !r_s2_v || s2_move;
        s1_move  = r_s1_v && s2_free;
        s1_free  = !r_s1_v || s1_move;
        accept   = s_axis_tvalid && s_axis_tready;
    end

    assign s_axis_tready = s1_free && !busy;
    assign o_cfg_ready   = 1'b1;

    rvx_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept),
        .i_ra    (in_instr.src_reg_a),
        .i_rb    (in_instr.src_reg_b),
        .o_qa    (qa),
        .o_qb    (qb),
        .i_we    (s2_move && r_s2_wr),
        .i_wa    (r_s2_rd),
        .i_wd    (s2_val)
    );

    // The write-back step's result overrides the stale register read.
    assign s2_val = r_s2_load ? load_value : r_s2_val;
    always_comb begin
        fa = (r_s2_v && r_s2_wr && r_s2_rd == r_s1_instr.src_reg_a) ? s2_val : qa;
        fb = (r_s2_v && r_s2_wr && r_s2_rd == r_s1_instr.src_reg_b) ? s2_val : qb;
    end

    rvx_alu #(.MEM_BYTES(MEM_BYTES)) u_alu (
        .i_instr (r_s1_instr),
        .i_pc    (r_pc),
        .i_a     (fa),
        .i_b     (fb),
        .o_res   (ex_res)
    );

    rvx_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (s1_move && ex_res.is_load),
        .i_wr_en      (s1_move && ex_res.is_store),
        .i_addr       (ex_res.addr),
        .i_size       (ex_res.size),
        .i_sub_op     (r_s1_instr.sub_op),
        .i_wdata      (fb),
        .o_busy       (busy),
        .o_load_value (load_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_out_v    <= 1'b0;
            r_pc       <= '0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_s2_v <= 1'b1;
            end else if (s2_move) begin
                r_s2_v <= 1'b0;
            end
            if (s2_move) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_pc       <= i_cfg_data;
            end else if (s1_move) begin
                r_pc <= ex_res.next_pc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_instr <= in_instr;
        end
        if (s1_move) begin
            r_s2_status <= ex_res.status;
            r_s2_pc     <= ex_res.next_pc;
            r_s2_wr     <= ex_res.wr;
            r_s2_rd     <= r_s1_instr.dest_reg;
            r_s2_load   <= ex_res.is_load;
            r_s2_val    <= ex_res.value;
        end
        if (s2_move) begin
            r_out <= {7'd0,
                      r_s2_wr ? s2_val : 32'd0,
                      r_s2_wr ? r_s2_rd : 5'd0,
                      r_s2_wr,
                      r_s2_pc,
                      r_s2_status};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

    // No instruction may enter while the data memory is being cleared.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !accept) else $error("request accepted during memory clear");

    // Register zero is never reported as written.
    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[35]) |-> (m_axis_tdata[40:36] != 5'd0))
        else $error("write-back to register zero");

    // Only a plain completion writes a register.
    a_wb_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2:0] != rvx_pkg::ST_OK) |-> !m_axis_tdata[35])
        else $error("write-back on a non-continue status");

    // Execution never advances while the write-back step is blocked.
    a_s1_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s2_v && !out_free) |=> (r_s1_v && $stable(r_pc)))
        else $error("execute step advanced into a blocked write-back step");

endmodule

`default_nettype wire

### bench/rv32i_execute_unit_tb.sv
// ----------------------------------------------------------------------------
// rv32i_execute_unit_tb
// Self-checking bench for the RV32I execute unit.
// ----------------------------------------------------------------------------
// Instructions go in on the request stream. An in-bench model of the
// registers, the program counter and the data memory predicts each result
// when its request is accepted. Every result is compared field by field with
// the oldest prediction. The run covers a directed set of corner cases and
// random programmes under changing stall patterns and start_pc settings.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_execute_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        rvx_pkg::t_status status;
        logic [31:0]      new_pc;
        logic             wb_enable;
        logic [4:0]       wb_index;
        logic [31:0]      wb_value;
    } t_exec_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;

    rv32i_execute_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Architectural state as the bench believes it to be.
    logic [31:0] arch_regs [32];
    logic [31:0] arch_pc;
    logic [7:0]  arch_mem [rvx_pkg::MEM_BYTES];

    t_exec_result pending_results[$];
    int           error_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_cycles;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Generous overall limit: covers the memory clearing pass after reset and
    // every result waiting out the heaviest receiver stalls.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic fits_memory(logic [31:0] addr, int unsigned size);
        return ({32'd0, addr} + size) <= rvx_pkg::MEM_BYTES;
    endfunction

    // Executes one instruction on the bench state and queues its result.
    task automatic retire_instr(rvx_pkg::t_instr ins);
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  addr;
        logic [31:0]  val;
        logic [31:0]  next;
        logic [4:0]   sh;
        logic         wr;
        logic         take;
        int unsigned  size;
        t_exec_result res;
        a      = arch_regs[ins.src_reg_a];
        b      = arch_regs[ins.src_reg_b];
        next   = arch_pc + 32'd4;
        val    = '0;
        wr     = 1'b0;
        take   = 1'b0;
        res.status = rvx_pkg::ST_OK;
        case (ins.major_opcode)
            rvx_pkg::OP_LUI: begin
                wr  = 1'b1;
                val = ins.immediate;
            end
            rvx_pkg::OP_AUIPC: begin
                wr  = 1'b1;
                val = arch_pc + ins.immediate;
            end
            rvx_pkg::OP_JAL: begin
                wr   = 1'b1;
                val  = next;
                next = arch_pc + ins.immediate;
            end
            rvx_pkg::OP_JALR: begin
                wr   = 1'b1;
                val  = next;
                next = (a + ins.immediate) & ~32'd1;
            end
            rvx_pkg::OP_BRANCH: begin
                case (ins.sub_op)
                    rvx_pkg::F3_BEQ:  take = (a == b);
                    rvx_pkg::F3_BNE:  take = (a != b);
                    rvx_pkg::F3_BLT:  take = ($signed(a) < $signed(b));
                    rvx_pkg::F3_BGE:  take = ($signed(a) >= $signed(b));
                    rvx_pkg::F3_BLTU: take = (a < b);
                    rvx_pkg::F3_BGEU: take = (a >= b);
                    default:          res.status = rvx_pkg::ST_ILLEGAL;
                endcase
                if (take) begin
                    next = arch_pc + ins.immediate;
                end
            end
            rvx_pkg::OP_LOAD: begin
                addr = a + ins.immediate;
                size = (ins.sub_op[1:0] == 2'd0) ? 1 : (ins.sub_op[1:0] == 2'd1) ? 2 : 4;
                if (!(ins.sub_op inside {rvx_pkg::F3_B, rvx_pkg::F3_H, rvx_pkg::F3_W,
                                         rvx_pkg::F3_BU, rvx_pkg::F3_HU})) begin
                    res.status = rvx_pkg::ST_ILLEGAL;
                end else if (!fits_memory(addr, size)) begin
                    res.status = rvx_pkg::ST_MEMFAULT;
                end else begin
                    for (int i = 0; i < size; i++) begin
                        val[8*i +: 8] = arch_mem[addr + i];
                    end
                    if (ins.sub_op == rvx_pkg::F3_B) begin
                        val = {{24{val[7]}}, val[7:0]};
                    end else if (ins.sub_op == rvx_pkg::F3_H) begin
                        val = {{16{val[15]}}, val[15:0]};
                    end
                    wr = 1'b1;
                end
            end
            rvx_pkg::OP_STORE: begin
                addr = a + ins.immediate;
                size = (ins.sub_op == rvx_pkg::F3_B) ? 1 : (ins.sub_op == rvx_pkg::F3_H) ? 2 : 4;
                if (ins.sub_op > rvx_pkg::F3_W) begin
                    res.status = rvx_pkg::ST_ILLEGAL;
                end else if (!fits_memory(addr, size)) begin
                    res.status = rvx_pkg::ST_MEMFAULT;
                end else begin
                    for (int i = 0; i < size; i++) begin
                        arch_mem[addr + i] = b[8*i +: 8];
                    end
                end
            end
            rvx_pkg::OP_IMM: begin
                sh = ins.immediate[4:0] & rvx_pkg::SHAMT_MASK;
                wr = 1'b1;
                case (ins.sub_op)
                    rvx_pkg::F3_ADD:  val = a + ins.immediate;
                    rvx_pkg::F3_SLL:  val = a << sh;
                    rvx_pkg::F3_SLT:  val = {31'd0, $signed(a) < $signed(ins.immediate)};
                    rvx_pkg::F3_SLTU: val = {31'd0, a < ins.immediate};
                    rvx_pkg::F3_XOR:  val = a ^ ins.immediate;
                    rvx_pkg::F3_SR:   val = ins.word_bit30 ? $unsigned($signed(a) >>> sh)
                                                           : a >> sh;
                    rvx_pkg::F3_OR:   val = a | ins.immediate;
                    default:          val = a & ins.immediate;
                endcase
            end
            rvx_pkg::OP_REG: begin
                sh = b[4:0] & rvx_pkg::SHAMT_MASK;
                wr = 1'b1;
                case (ins.sub_op)
                    rvx_pkg::F3_ADD:  val = (ins.alt_op == rvx_pkg::F7_ALT) ? a - b : a + b;
                    rvx_pkg::F3_SLL:  val = a << sh;
                    rvx_pkg::F3_SLT:  val = {31'd0, $signed(a) < $signed(b)};
                    rvx_pkg::F3_SLTU: val = {31'd0, a < b};
                    rvx_pkg::F3_XOR:  val = a ^ b;
                    rvx_pkg::F3_SR:   val = (ins.alt_op == rvx_pkg::F7_ALT)
                                          ? $unsigned($signed(a) >>> sh) : a >> sh;
                    rvx_pkg::F3_OR:   val = a | b;
                    default:          val = a & b;
                endcase
            end
            rvx_pkg::OP_SYSTEM: begin
                if (ins.sub_op == 3'd0 && ins.immediate == 32'd0) begin
                    res.status = rvx_pkg::ST_ECALL;
                end else if (ins.sub_op == 3'd0 && ins.immediate == 32'd1) begin
                    res.status = rvx_pkg::ST_EBREAK;
                end else begin
                    res.status = rvx_pkg::ST_ILLEGAL;
                end
            end
            rvx_pkg::OP_FENCE: ;
            default: res.status = rvx_pkg::ST_ILLEGAL;
        endcase
        // Faulting instructions leave every piece of state untouched.
        if (res.status == rvx_pkg::ST_ILLEGAL || res.status == rvx_pkg::ST_MEMFAULT) begin
            next = arch_pc;
            wr   = 1'b0;
        end
        if (ins.dest_reg == 5'd0) begin
            wr = 1'b0;
        end
        if (wr) begin
            arch_regs[ins.dest_reg] = val;
        end
        arch_pc       = next;
        res.new_pc    = next;
        res.wb_enable = wr;
        res.wb_index  = wr ? ins.dest_reg : 5'd0;
        res.wb_value  = wr ? val : 32'd0;
        pending_results.push_back(res);
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_exec_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: %h", m_axis_tdata);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_axis_tdata[2:0] !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, m_axis_tdata[2:0]);
                    error_count++;
                end
                if (m_axis_tdata[34:3] !== exp_res.new_pc) begin
                    $error("new_pc: expected %h, got %h", exp_res.new_pc, m_axis_tdata[34:3]);
                    error_count++;
                end
                if (m_axis_tdata[35] !== exp_res.wb_enable) begin
                    $error("wb_enable: expected %b, got %b", exp_res.wb_enable, m_axis_tdata[35]);
                    error_count++;
                end
                if (m_axis_tdata[40:36] !== exp_res.wb_index) begin
                    $error("wb_index: expected %0d, got %0d", exp_res.wb_index,
                           m_axis_tdata[40:36]);
                    error_count++;
                end
                if (m_axis_tdata[72:41] !== exp_res.wb_value) begin
                    $error("wb_value: expected %h, got %h", exp_res.wb_value,
                           m_axis_tdata[72:41]);
                    error_count++;
                end
            end
        end
    end

    // The receiver stalls at random, or for a whole hold-off stretch when one
    // has been requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready = 1'b0;
            hold_cycles--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Offers one request and predicts its result once it is accepted. The
    // valid stays high afterwards so that back-to-back requests are possible.
    task automatic issue_instr(rvx_pkg::t_instr ins);
        if ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'd0, ins};
        do @(posedge i_clk); while (!s_axis_tready);
        retire_instr(ins);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic rvx_pkg::t_instr make_instr(logic [6:0] op, logic [4:0] rd,
                                                   logic [4:0] rs1, logic [4:0] rs2,
                                                   logic [2:0] f3, logic [31:0] imm);
        rvx_pkg::t_instr ins;
        ins.major_opcode = op;
        ins.dest_reg     = rd;
        ins.src_reg_a    = rs1;
        ins.src_reg_b    = rs2;
        ins.sub_op       = f3;
        ins.alt_op       = 7'd0;
        ins.immediate    = imm;
        ins.word_bit30   = 1'b0;
        return ins;
    endfunction

    // Mostly well-formed instructions with random content; memory accesses
    // are steered to a small hot region and to the end of memory.
    function automatic rvx_pkg::t_instr random_instr();
        rvx_pkg::t_instr ins;
        int unsigned     pick;
        logic [31:0]     target;
        ins  = rvx_pkg::t_instr'(65'({$urandom, $urandom, $urandom}));
        pick = $urandom_range(99);
        target = ($urandom_range(9) < 8) ? $urandom_range(63)
               : ($urandom_range(1) ? rvx_pkg::MEM_BYTES - $urandom_range(6) : $urandom);
        if (pick < 6) begin
            return ins;
        end else if (pick < 16) begin
            ins.major_opcode = rvx_pkg::OP_LUI;
        end else if (pick < 20) begin
            ins.major_opcode = rvx_pkg::OP_AUIPC;
        end else if (pick < 24) begin
            ins.major_opcode = rvx_pkg::OP_JAL;
        end else if (pick < 27) begin
            ins.major_opcode = rvx_pkg::OP_JALR;
        end else if (pick < 37) begin
            ins.major_opcode = rvx_pkg::OP_BRANCH;
            if ($urandom_range(1)) begin
                ins.src_reg_b = ins.src_reg_a;
            end
        end else if (pick < 52) begin
            ins.major_opcode = rvx_pkg::OP_LOAD;
            ins.immediate    = target - arch_regs[ins.src_reg_a];
        end else if (pick < 64) begin
            ins.major_opcode = rvx_pkg::OP_STORE;
            ins.immediate    = target - arch_regs[ins.src_reg_a];
            ins.sub_op       = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 3))
                                                        : 3'($urandom_range(2));
        end else if (pick < 84) begin
            ins.major_opcode = rvx_pkg::OP_IMM;
            if ($urandom_range(1)) begin
                ins.immediate = {{20{ins.immediate[11]}}, ins.immediate[11:0]};
            end
        end else if (pick < 96) begin
            ins.major_opcode = rvx_pkg::OP_REG;
            if ($urandom_range(1)) begin
                ins.alt_op = rvx_pkg::F7_ALT;
            end
        end else if (pick < 98) begin
            ins.major_opcode = rvx_pkg::OP_SYSTEM;
            if ($urandom_range(3) != 0) begin
                ins.sub_op    = 3'd0;
                ins.immediate = $urandom_range(1);
            end
        end else begin
            ins.major_opcode = rvx_pkg::OP_FENCE;
        end
        return ins;
    endfunction

    task automatic test_start_pc(logic [31:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        arch_pc = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_directed();
        rvx_pkg::t_instr ins;
        issue_instr(make_instr(rvx_pkg::OP_LUI, 5'd1, 5'd0, 5'd0, 3'd0, 32'hFFFF_F000));
        issue_instr(make_instr(rvx_pkg::OP_LUI, 5'd0, 5'd0, 5'd0, 3'd0, 32'h1234_5000));
        issue_instr(make_instr(rvx_pkg::OP_IMM, 5'd2, 5'd0, 5'd0, rvx_pkg::F3_ADD,
                               32'h0000_0010));
        issue_instr(make_instr(rvx_pkg::OP_AUIPC, 5'd31, 5'd0, 5'd0, 3'd0, 32'h8000_0000));
        // Misaligned word store, then every load width back from it, the halfword and word loads misaligned.
        issue_instr(make_instr(rvx_pkg::OP_STORE, 5'd0, 5'd2, 5'd1, rvx_pkg::F3_W, 32'd1));
        issue_instr(make_instr(rvx_pkg::OP_LOAD, 5'd3, 5'd2, 5'd0, rvx_pkg::F3_B, 32'd2));
        issue_instr(make_instr(rvx_pkg::OP_LOAD, 5'd4, 5'd2, 5'd0, rvx_pkg::F3_HU, 32'd3));
        issue_instr(make_instr(rvx_pkg::OP_LOAD, 5'd5, 5'd2, 5'd0, rvx_pkg::F3_H, 32'd3));
        issue_instr(make_instr(rvx_pkg::OP_LOAD, 5'd6, 5'd2, 5'd0, rvx_pkg::F3_W, 32'd1));
        issue_instr(make_instr(rvx_pkg::OP_LOAD, 5'd7, 5'd2, 5'd0, rvx_pkg::F3_BU, 32'd4));
        // Accesses at the end of memory: two that run past it, one by wrapping round, and a halfword that just fits.
        issue_instr(make_instr(rvx_pkg::OP_LOAD, 5'd8, 5'd0, 5'd0, rvx_pkg::F3_W,
                               rvx_pkg::MEM_BYTES - 2));
        issue_instr(make_instr(rvx_pkg::OP_STORE, 5'd0, 5'd0, 5'd1, rvx_pkg::F3_B,
                               32'hFFFF_FFFF));
        issue_instr(make_instr(rvx_pkg::OP_STORE, 5'd0, 5'd0, 5'd1, rvx_pkg::F3_H,
                               rvx_pkg::MEM_BYTES - 2));
        // Illegal encodings, then ECALL, EBREAK, a bad SYSTEM code and FENCE.
        issue_instr(make_instr(rvx_pkg::OP_LOAD, 5'd9, 5'd0, 5'd0, 3'd3, 32'd0));
        issue_instr(make_instr(rvx_pkg::OP_STORE, 5'd0, 5'd0, 5'd0, 3'd3, 32'd0));
        issue_instr(make_instr(rvx_pkg::OP_BRANCH, 5'd0, 5'd1, 5'd1, 3'd2, 32'd8));
        issue_instr(make_instr(7'h7F, 5'd9, 5'd0, 5'd0, 3'd0, 32'd0));
        issue_instr(make_instr(rvx_pkg::OP_SYSTEM, 5'd0, 5'd0, 5'd0, 3'd0, 32'd0));
        issue_instr(make_instr(rvx_pkg::OP_SYSTEM, 5'd0, 5'd0, 5'd0, 3'd0, 32'd1));
        issue_instr(make_instr(rvx_pkg::OP_SYSTEM, 5'd0, 5'd0, 5'd0, 3'd0, 32'd2));
        issue_instr(make_instr(rvx_pkg::OP_FENCE, 5'd9, 5'd0, 5'd0, 3'd0, 32'd0));
        // Signed against unsigned compare, an arithmetic and a logical shift, SUB, jumps.
        issue_instr(make_instr(rvx_pkg::OP_BRANCH, 5'd0, 5'd1, 5'd2, rvx_pkg::F3_BLT,
                               32'hFFFF_FFF0));
        issue_instr(make_instr(rvx_pkg::OP_BRANCH, 5'd0, 5'd1, 5'd2, rvx_pkg::F3_BLTU,
                               32'd12));
        ins = make_instr(rvx_pkg::OP_IMM, 5'd10, 5'd1, 5'd0, rvx_pkg::F3_SR, 32'h0000_041F);
        ins.word_bit30 = 1'b1;
        ins.alt_op     = 7'h5F;
        issue_instr(ins);
        ins = make_instr(rvx_pkg::OP_REG, 5'd11, 5'd2, 5'd1, rvx_pkg::F3_ADD, 32'd0);
        ins.alt_op = rvx_pkg::F7_ALT;
        issue_instr(ins);
        ins = make_instr(rvx_pkg::OP_REG, 5'd12, 5'd1, 5'd2, rvx_pkg::F3_SR, 32'd0);
        ins.alt_op = 7'h7F;
        issue_instr(ins);
        issue_instr(make_instr(rvx_pkg::OP_JALR, 5'd13, 5'd2, 5'd0, 3'd5, 32'd7));
        issue_instr(make_instr(rvx_pkg::OP_JAL, 5'd14, 5'd0, 5'd0, 3'd0, 32'hFFFF_FFFC));
    endtask

    task automatic test_random(int count);
        repeat (count) issue_instr(random_instr());
    endtask

    // The receiver holds off while requests keep coming, so that the unit
    // fills up and has to stall its input.
    task automatic test_backpressure();
        hold_cycles = 300;
        test_random(40);
    endtask

    initial begin
        error_count   = 0;
        hold_cycles   = 0;
        send_idle_pct = 28;
        recv_idle_pct = 82;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        arch_pc       = '0;
        foreach (arch_regs[i]) arch_regs[i] = '0;
        foreach (arch_mem[i]) arch_mem[i] = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(440);
        test_start_pc(32'hFFFF_FFFC);

        send_idle_pct = 82;
        recv_idle_pct = 28;
        test_random(440);
        test_backpressure();
        test_start_pc($urandom);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_start_pc(32'hFFFF_FFFF);
        test_random(100);
        test_start_pc(32'd0);
        test_random(360);

        drain_results();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hdl/rvx_pkg.sv
hdl/rvx_regfile.sv
hdl/rvx_alu.sv
hdl/rvx_dmem.sv
hdl/rv32i_execute_unit.sv
bench/rv32i_execute_unit_tb.sv
